>>> hdl/pfks_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Priority-flag-then-key sorter package
// Shared sizes, transaction payload types and the sort key type.
// ----------------------------------------------------------------------------
package pfks_pkg;

    localparam int MAX_RECORDS = 32;
    localparam int KEY_WIDTH   = 16;

    // Fixed field widths of the transaction payloads.
    localparam int KEY_FIELD_W = 16;
    localparam int POS_FIELD_W = 5;

    // Index into the record store and a count that can hold the depth itself.
    localparam int IDX_W = $clog2(MAX_RECORDS);
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);

    // Stored record: priority flag above the key.
    localparam int REC_W = 1 + KEY_WIDTH;

    typedef struct packed {
        logic [KEY_FIELD_W-1:0] key_value;
        logic                   priority_flag;
        logic                   is_last;
    } t_in_item;

    typedef struct packed {
        logic [KEY_FIELD_W-1:0] key_out;
        logic                   priority_out;
        logic [POS_FIELD_W-1:0] load_position;
        logic                   end_of_run;
        logic                   overflowed;
    } t_out_item;

    // Total order of the sort: priority records first (inverted flag), then
    // ascending key, then ascending load position. No two records compare equal.
    typedef struct packed {
        logic                 grp;
        logic [KEY_WIDTH-1:0] key;
        logic [IDX_W-1:0]     idx;
    } t_sort_key;

endpackage
`default_nettype wire

>>> hdl/pfks_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pfks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

>>> hdl/priority_flag_then_key_sorter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Priority-flag-then-key sorter
// Loads records into a RAM and emits them sorted by priority, key and order.
// ----------------------------------------------------------------------------
// Each accepted input transaction stores one record (key and priority flag) at
// the next free RAM entry, one transaction per cycle. The transaction that
// carries is_last starts the output burst: every loaded record comes out once,
// priority records first, each group in ascending key order, equal keys in load
// order, with the load position as handle. Records arriving while the store is
// full are dropped and every result of that burst reports overflowed. No input
// is accepted during a burst. The sort is a repeated selection over the single
// read port of the record RAM: for each result the block reads all n loaded
// entries, one per cycle, and keeps the smallest record that lies above the one
// emitted before. A scan ends when the read data of the last entry has been
// checked; the result is then offered and held while the receiver stalls.
// The store needs no clearing: only entries below the fill count are read.
// ----------------------------------------------------------------------------
module priority_flag_then_key_sorter
    import pfks_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    // Load while idle, scan the store for the next record, then present it.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_fill, n_fill;         // records in the store
    logic             r_ovf, n_ovf;           // a record was dropped this load
    logic [CNT_W-1:0] r_issue, n_issue;       // next address of the scan
    logic             r_dv, n_dv;             // RAM read data valid
    logic [IDX_W-1:0] r_didx, n_didx;         // address of that read data
    logic [CNT_W-1:0] r_emitted, n_emitted;   // results delivered this burst
    logic             r_have_best, n_have_best;
    logic             r_have_last, n_have_last;
    t_sort_key        r_best, n_best;         // best candidate of this scan
    t_sort_key        r_last, n_last;         // record emitted last

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [REC_W-1:0] wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [REC_W-1:0] rd_data;
    t_sort_key        cand;
    logic             in_fire;
    logic             last_result;

    pfks_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_RECORDS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Record arriving from the RAM, turned into its sort key. The stored word
    // holds the priority flag above the key; the position is the address.
    always_comb begin
        cand.grp = ~rd_data[REC_W-1];
        cand.key = rd_data[KEY_WIDTH-1:0];
        cand.idx = r_didx;
    end

    assign in_fire     = i_in_valid && o_in_ready;
    assign last_result = (r_emitted + CNT_W'(1)) == r_fill;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_ovf       = r_ovf;
        n_issue     = r_issue;
        n_dv        = 1'b0;
        n_didx      = r_didx;
        n_emitted   = r_emitted;
        n_have_best = r_have_best;
        n_have_last = r_have_last;
        n_best      = r_best;
        n_last      = r_last;
        wr_en       = 1'b0;
        wr_addr     = r_fill[IDX_W-1:0];
        wr_data     = {i_in_data.priority_flag, KEY_WIDTH'(i_in_data.key_value)};
        rd_en       = 1'b0;
        rd_addr     = r_issue[IDX_W-1:0];
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_fire) begin
                    if (r_fill < CNT_W'(MAX_RECORDS)) begin
                        wr_en  = 1'b1;
                        n_fill = r_fill + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_data.is_last) begin
                        n_state     = ST_SCAN;
                        n_issue     = '0;
                        n_emitted   = '0;
                        n_have_best = 1'b0;
                        n_have_last = 1'b0;
                    end
                end
            end

            ST_SCAN: begin
                // Issue one read per cycle over the loaded entries.
                if (r_issue < r_fill) begin
                    rd_en   = 1'b1;
                    n_issue = r_issue + CNT_W'(1);
                    n_dv    = 1'b1;
                    n_didx  = r_issue[IDX_W-1:0];
                end
                // Keep the smallest record above the one emitted before.
                if (r_dv) begin
                    if ((!r_have_last || cand > r_last) &&
                        (!r_have_best || cand < r_best)) begin
                        n_best      = cand;
                        n_have_best = 1'b1;
                    end
                    if (CNT_W'(r_didx) == r_fill - CNT_W'(1)) begin
                        n_state = ST_EMIT;
                        n_dv    = 1'b0;
                    end
                end
            end

            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_last      = r_best;
                    n_have_last = 1'b1;
                    n_have_best = 1'b0;
                    n_issue     = '0;
                    n_emitted   = r_emitted + CNT_W'(1);
                    if (last_result) begin
                        n_state     = ST_IDLE;
                        n_fill      = '0;
                        n_ovf       = 1'b0;
                        n_emitted   = '0;
                        n_have_last = 1'b0;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_out_data.key_out       = KEY_FIELD_W'(r_best.key);
        o_out_data.priority_out  = ~r_best.grp;
        o_out_data.load_position = POS_FIELD_W'(r_best.idx);
        o_out_data.end_of_run    = last_result;
        o_out_data.overflowed    = r_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_issue     <= '0;
            r_dv        <= 1'b0;
            r_emitted   <= '0;
            r_have_best <= 1'b0;
            r_have_last <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_ovf       <= n_ovf;
            r_issue     <= n_issue;
            r_dv        <= n_dv;
            r_emitted   <= n_emitted;
            r_have_best <= n_have_best;
            r_have_last <= n_have_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_didx <= n_didx;
        r_best <= n_best;
        r_last <= n_last;
    end

endmodule
`default_nettype wire
